// ===== rtl/core/spa_pkg.sv =====
`default_nettype none

package spa_pkg;

    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int POOL_IDX_W  = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CFG_REGS = 4;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_NO_FIT   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BAD_FREE = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [ADDR_W-1:0]     block_address;
        logic [POOL_IDX_W-1:0] pool_index;
    } t_rsp;

    // reset base address of pool p; pools past the register list sit at 0
    function automatic logic [ADDR_W-1:0] pool_base_rst(input int p);
        logic [ADDR_W-1:0] v;
        case (p)
            1:       v = 32'd256;
            2:       v = 32'd768;
            3:       v = 32'd1792;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/segregated_pool_allocator_core.sv =====
// Timing: a request taken with start is held in the input register, resolved from it, and its
//   result is written into the result register, which drives the result strobe.
// Throughput: one request per clock; busy never rises, as every free-list update
//   completes within the single resolve stage that follows the input register.
// Reset (synchronous, active low): every pool's free list holds all its chunks in order,
//   no chunk in use, pool bases at their defaults. Results cannot be stalled.
`default_nettype none

module segregated_pool_allocator_core #(
    parameter int POOLS           = 4,
    parameter int CHUNKS          = 16,
    parameter int HEADER_BYTES    = 8,
    parameter int MIN_CHUNK_SHIFT = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire spa_pkg::t_req                     i_req,
    // result channel
    output logic                                   o_result_strobe,
    output spa_pkg::t_rsp                          o_rsp,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [spa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [spa_pkg::ADDR_W-1:0]        i_cfg_data
);

    localparam int AW = spa_pkg::ADDR_W;
    localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;   // chunk index
    localparam int NW = $clog2(CHUNKS + 1);                   // free count
    localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;      // pool select
    localparam logic [AW-1:0] HDR   = AW'(HEADER_BYTES);
    localparam logic [AW:0]   HDR_X = (AW + 1)'(HEADER_BYTES);

    // ------------------------------------------------------------------
    // Input register: one request enters every cycle that start is high.
    // ------------------------------------------------------------------
    logic          r_in_vld;
    spa_pkg::t_req r_in;

    // Pool state. Each pool's free list is a circular FIFO of chunk indices.
    logic [AW-1:0]     r_base   [POOLS];
    logic [CW-1:0]     r_slot   [POOLS][CHUNKS];
    logic [CW-1:0]     r_head   [POOLS];
    logic [NW-1:0]     r_count  [POOLS];
    logic [CHUNKS-1:0] r_in_use [POOLS];

    // Result register
    logic          r_out_vld;
    spa_pkg::t_rsp r_out;
    spa_pkg::t_rsp n_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Per-pool lanes, all evaluated in parallel on the registered request.
    // ------------------------------------------------------------------
    logic [POOLS-1:0] fit_vec;       // rounded size fits this pool's chunk
    logic [POOLS-1:0] hit_vec;       // free address is an in-use chunk here
    logic [CW-1:0]    head_chunk [POOLS];
    logic [CW-1:0]    head_next  [POOLS];
    logic [CW-1:0]    tail_slot  [POOLS];
    logic [CW-1:0]    free_chunk [POOLS];
    logic [AW-1:0]    alloc_addr [POOLS];
    logic [AW-1:0]    node_addr;
    logic [AW:0]      need_bytes;

    // size + header fits a chunk exactly when its round-up to the granule does,
    // since every chunk size is a multiple of the granule
    assign need_bytes = {1'b0, r_in.request_size} + HDR_X;
    assign node_addr  = r_in.free_address - HDR;

    for (genvar gp = 0; gp < POOLS; gp++) begin : g_pool
        localparam int            SHIFT    = MIN_CHUNK_SHIFT + gp;
        localparam logic [AW:0]   CAP      = (AW + 1)'(1) << SHIFT;
        localparam logic [AW-1:0] LOW_MASK = (AW'(1) << SHIFT) - AW'(1);

        logic [AW-1:0] off;
        logic [AW-1:0] chunk_no;
        logic [NW:0]   tail_sum;

        assign fit_vec[gp]    = (need_bytes <= CAP);
        assign head_chunk[gp] = r_slot[gp][r_head[gp]];
        assign head_next[gp]  = (r_head[gp] == CW'(CHUNKS - 1)) ? '0 : r_head[gp] + CW'(1);
        assign alloc_addr[gp] = r_base[gp] + (AW'(head_chunk[gp]) << SHIFT) + HDR;

        // free: offset into the pool must be chunk aligned and inside the pool
        assign off            = node_addr - r_base[gp];
        assign chunk_no       = off >> SHIFT;
        assign free_chunk[gp] = chunk_no[CW-1:0];
        assign hit_vec[gp]    = ((off & LOW_MASK) == '0) && (chunk_no < AW'(CHUNKS))
                                && r_in_use[gp][free_chunk[gp]];

        // tail = (head + count) mod CHUNKS; the sum stays below twice CHUNKS
        assign tail_sum      = (NW + 1)'(r_head[gp]) + (NW + 1)'(r_count[gp]);
        assign tail_slot[gp] = (tail_sum >= (NW + 1)'(CHUNKS))
                               ? CW'(tail_sum - (NW + 1)'(CHUNKS)) : CW'(tail_sum);
    end

    // First fitting pool, and lowest pool index that owns the freed chunk
    logic [PW-1:0] alloc_sel;
    logic [PW-1:0] free_sel;

    always_comb begin
        alloc_sel = '0;
        free_sel  = '0;
        for (int p = POOLS - 1; p >= 0; p--) begin
            if (fit_vec[p]) begin
                alloc_sel = PW'(p);
            end
            if (hit_vec[p]) begin
                free_sel = PW'(p);
            end
        end
    end

    // ------------------------------------------------------------------
    // Resolve: status, pointer and the free-list action for this request.
    // ------------------------------------------------------------------
    logic          do_pop;
    logic          do_push;
    logic [PW-1:0] act_pool;

    always_comb begin
        n_out    = '0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        act_pool = '0;
        case (r_in.command)
            spa_pkg::CMD_ALLOC: begin
                if (r_in.request_size == '0) begin
                    n_out.status = spa_pkg::ST_NULL;
                end else if (fit_vec == '0) begin
                    n_out.status = spa_pkg::ST_NO_FIT;
                end else if (r_count[alloc_sel] == '0) begin
                    // no fallback to a larger pool
                    n_out.status = spa_pkg::ST_EMPTY;
                end else begin
                    n_out.status        = spa_pkg::ST_OK;
                    n_out.block_address = alloc_addr[alloc_sel];
                    n_out.pool_index    = spa_pkg::POOL_IDX_W'(alloc_sel);
                    do_pop              = 1'b1;
                    act_pool            = alloc_sel;
                end
            end
            spa_pkg::CMD_FREE: begin
                if (r_in.free_address == '0) begin
                    n_out.status = spa_pkg::ST_NULL;
                end else if (hit_vec == '0) begin
                    // misaligned, out of range, or already free
                    n_out.status = spa_pkg::ST_BAD_FREE;
                end else begin
                    n_out.status     = spa_pkg::ST_OK;
                    n_out.pool_index = spa_pkg::POOL_IDX_W'(free_sel);
                    do_push          = 1'b1;
                    act_pool         = free_sel;
                end
            end
            default: begin
                n_out.status = spa_pkg::ST_NULL;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_req;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int p = 0; p < POOLS; p++) begin
                r_base[p]   <= spa_pkg::pool_base_rst(p);
                r_head[p]   <= '0;
                r_count[p]  <= NW'(CHUNKS);
                r_in_use[p] <= '0;
                for (int c = 0; c < CHUNKS; c++) begin
                    r_slot[p][c] <= CW'(c);
                end
            end
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
            for (int p = 0; p < POOLS; p++) begin
                if (i_cfg_valid && o_cfg_ready && (p < spa_pkg::NUM_CFG_REGS)
                    && (i_cfg_index == spa_pkg::CFG_IDX_W'(p))) begin
                    r_base[p] <= i_cfg_data;
                end
                if (r_in_vld && do_pop && (act_pool == PW'(p))) begin
                    r_head[p]                   <= head_next[p];
                    r_count[p]                  <= r_count[p] - NW'(1);
                    r_in_use[p][head_chunk[p]]  <= 1'b1;
                end
                if (r_in_vld && do_push && (act_pool == PW'(p))) begin
                    r_slot[p][tail_slot[p]]     <= free_chunk[p];
                    r_count[p]                  <= r_count[p] + NW'(1);
                    r_in_use[p][free_chunk[p]]  <= 1'b0;
                end
            end
        end
    end

    assign o_result_strobe = r_out_vld;
    assign o_rsp           = r_out;

`ifndef SYNTH
    // every registered request yields exactly one strobe on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_result_strobe)
        else $error("request produced no result strobe");

    // a failed request never hands out a pointer or a pool
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_rsp.status != spa_pkg::ST_OK))
            |-> ((o_rsp.block_address == '0) && (o_rsp.pool_index == '0)))
        else $error("failed request carries pointer or pool");

    for (genvar ap = 0; ap < POOLS; ap++) begin : g_pool_chk
        // free count and in-use map always account for every chunk
        a_chunk_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (int'(r_count[ap]) + $countones(r_in_use[ap])) == CHUNKS)
            else $error("pool chunk accounting broken");

        // free list only moves when a request was being resolved
        a_count_moves_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !$stable(r_count[ap]) |-> $past(r_in_vld))
            else $error("free count changed without a request");
    end
`endif

endmodule

`default_nettype wire
